// ===== src/uer_pkg.sv =====
// ----------------------------------------------------------------------------
// uer_pkg: shared types and constants of the ultrasonic echo ranger
// phase codes, job flags between front and back, reciprocal constants
// ----------------------------------------------------------------------------
package uer_pkg;

  // default echo counter width
  localparam int ECHO_BITS_DEF = 16;

  // depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // register reset values
  localparam logic [19:0] PERIOD_RESET  = 20'd550000;
  localparam logic [7:0]  TRIGGER_RESET = 8'd15;

  // register indexes, taken from paddr[2]
  localparam logic REG_PERIOD  = 1'b0;
  localparam logic REG_TRIGGER = 1'b1;

  // floor(2^32 / 125), used for x / 125 with one correction step
  localparam int          RECIP125_BITS  = 26;
  localparam logic [25:0] RECIP125       = 26'd34359738;
  localparam int          RECIP125_SHIFT = 32;

  // ceil(2^23 / 10), exact for values below 2^22
  localparam int          RECIP10_BITS  = 20;
  localparam logic [19:0] RECIP10       = 20'd838861;
  localparam int          RECIP10_SHIFT = 23;

  // display characters and distance limit
  localparam logic [6:0]  CHAR_ZERO = 7'h30;
  localparam logic [6:0]  CHAR_DASH = 7'h2D;
  localparam logic [10:0] DIST_MAX  = 11'd2047;

  // measurement phase
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_TRIG  = 2'd1,
    PH_WAIT  = 2'd2,
    PH_COUNT = 2'd3
  } phase_t;

  // per-tick job flags handed from front to back
  typedef struct packed {
    logic timeout;
    logic valid;
    logic trig;
  } job_t;

  localparam int JOB_BITS = $bits(job_t);

endpackage

// ===== src/uer_front.sv =====
// ----------------------------------------------------------------------------
// uer_front: measurement sequencer
// consumes one tick per transfer and emits one job with flags and echo count
// ----------------------------------------------------------------------------
module uer_front #(
  parameter int ECHO_COUNTER_BITS = uer_pkg::ECHO_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         tick,
  input  logic                         echo_level,
  input  logic [19:0]                  period_ticks,
  input  logic [7:0]                   trigger_ticks,
  output uer_pkg::job_t                job,
  output logic [ECHO_COUNTER_BITS-1:0] job_count
);
  import uer_pkg::*;

  localparam logic [ECHO_COUNTER_BITS-1:0] ECHO_MAX = '1;
  localparam logic [ECHO_COUNTER_BITS-1:0] ECHO_ONE = ECHO_COUNTER_BITS'(1);

  phase_t                       phase, phase_next;
  logic [19:0]                  period_count, period_count_next;
  logic [7:0]                   pulse_count, pulse_count_next;
  logic [ECHO_COUNTER_BITS-1:0] echo_count, echo_count_next;
  logic                         overflow_seen, overflow_seen_next;
  logic [19:0]                  period_inc;
  logic [7:0]                   pulse_inc;
  logic                         period_done, pulse_done, echo_full;

  assign period_inc  = period_count + 20'd1;
  assign pulse_inc   = pulse_count + 8'd1;
  assign period_done = (period_inc >= period_ticks);
  assign pulse_done  = (pulse_inc >= trigger_ticks);
  assign echo_full   = (echo_count == ECHO_MAX);

  // next phase
  always_comb begin
    phase_next = phase;
    unique case (phase)
      PH_IDLE:  if (period_done) phase_next = PH_TRIG;
      PH_TRIG:  if (pulse_done) phase_next = PH_WAIT;
      PH_WAIT:  if (echo_level) phase_next = PH_COUNT;
      PH_COUNT: if (!echo_level || echo_full) phase_next = PH_IDLE;
      default:  phase_next = PH_IDLE;
    endcase
  end

  // counters and job for this tick
  always_comb begin
    period_count_next  = period_count;
    pulse_count_next   = pulse_count;
    echo_count_next    = echo_count;
    overflow_seen_next = overflow_seen;
    job                = '0;
    job_count          = '0;
    unique case (phase)
      PH_IDLE: begin
        if (period_done) begin
          period_count_next  = '0;
          pulse_count_next   = '0;
          echo_count_next    = '0;
          overflow_seen_next = 1'b0;
        end else begin
          period_count_next = period_inc;
        end
      end
      PH_TRIG: begin
        job.trig         = 1'b1;
        pulse_count_next = pulse_done ? 8'd0 : pulse_inc;
      end
      PH_WAIT: begin
        if (echo_level) echo_count_next = ECHO_ONE;
      end
      PH_COUNT: begin
        if (echo_level) begin
          if (echo_full) begin
            // counter overflow ends the measurement as a timeout
            echo_count_next    = '0;
            overflow_seen_next = 1'b1;
            period_count_next  = '0;
            job.valid          = 1'b1;
            job.timeout        = 1'b1;
          end else begin
            echo_count_next = echo_count + ECHO_ONE;
          end
        end else begin
          period_count_next = '0;
          job.valid         = 1'b1;
          job.timeout       = overflow_seen;
          job_count         = echo_count;
        end
      end
      default: ;
    endcase
  end

  // state registers, advance on each accepted tick
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      period_count  <= '0;
      pulse_count   <= '0;
      echo_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (tick) begin
      phase         <= phase_next;
      period_count  <= period_count_next;
      pulse_count   <= pulse_count_next;
      echo_count    <= echo_count_next;
      overflow_seen <= overflow_seen_next;
    end
  end

endmodule

// ===== src/uer_queue.sv =====
// ----------------------------------------------------------------------------
// uer_queue: small job queue
// decouples the tick sequencer from the distance and digit pipeline
// ----------------------------------------------------------------------------
module uer_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = uer_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);
  import uer_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] slots [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_push, do_pop;

  assign full      = (fill == CW'(DEPTH));
  assign not_empty = (fill != '0);
  assign head      = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + PW'(1);
      if (do_pop) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + PW'(1);
      if (do_push && !do_pop) fill <= fill + CW'(1);
      else if (do_pop && !do_push) fill <= fill - CW'(1);
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_data;
  end

endmodule

// ===== src/uer_back.sv =====
// ----------------------------------------------------------------------------
// uer_back: distance and digit pipeline
// count*17/1000 by reciprocal, then four decimal digits, one per stage
// ----------------------------------------------------------------------------
module uer_back #(
  parameter int ECHO_COUNTER_BITS = uer_pkg::ECHO_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         job_avail,
  input  uer_pkg::job_t                job,
  input  logic [ECHO_COUNTER_BITS-1:0] job_count,
  output logic                         job_take,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_trigger,
  output logic                         out_result,
  output logic                         out_timeout,
  output logic [10:0]                  out_distance,
  output logic [6:0]                   out_thousands,
  output logic [6:0]                   out_hundreds,
  output logic [6:0]                   out_tens,
  output logic [6:0]                   out_ones
);
  import uer_pkg::*;

  localparam int CB  = ECHO_COUNTER_BITS;
  localparam int PWD = CB + 5;                 // count*17
  localparam int XW  = CB + 2;                 // count*17 / 8
  localparam int MW  = XW + RECIP125_BITS;     // x * recip125
  localparam int DW  = CB - 4;                 // distance before saturation
  localparam int TW  = DW + RECIP10_BITS;      // value * recip10
  localparam int NST = 9;                      // stages incl. output register

  logic               adv;
  logic [NST-1:0]     vld;
  job_t               fl [0:NST-2];

  logic [PWD-1:0]     prod17;
  logic [XW-1:0]      x1, x2;
  logic [MW-1:0]      mul125;
  logic [DW-1:0]      q0;
  logic [XW-1:0]      rem;
  logic [DW-1:0]      dist_raw;

  logic [DW-1:0]      dval [0:4];
  logic [TW-1:0]      dmul [0:4];
  logic [10:0]        dsat [0:4];
  logic [15:0]        digs [0:4];

  // whole pipe moves together when the output register can take a word
  assign adv      = !vld[NST-1] || out_ready;
  assign job_take = adv && job_avail;
  assign out_valid = vld[NST-1];

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], job_avail};
    end
  end

  // flags follow their data
  always_ff @(posedge clk) begin
    if (adv) begin
      fl[0] <= job;
      for (int i = 1; i < NST - 1; i++) fl[i] <= fl[i-1];
    end
  end

  // stage 0: count*17 as shift and add
  always_ff @(posedge clk) begin
    if (adv) prod17 <= PWD'(job_count) + (PWD'(job_count) << 4);
  end

  // stage 1: x = count*17/8, multiply by reciprocal of 125
  always_ff @(posedge clk) begin
    if (adv) begin
      x1     <= prod17[PWD-1:3];
      mul125 <= MW'(prod17[PWD-1:3]) * MW'(RECIP125);
    end
  end

  // stage 2: quotient estimate, low by at most one
  always_ff @(posedge clk) begin
    if (adv) begin
      q0 <= mul125[MW-1:RECIP125_SHIFT];
      x2 <= x1;
    end
  end

  // stage 3: correct the estimate, saturate, start the first digit
  assign rem      = x2 - ((XW'(q0) << 7) - (XW'(q0) << 2) + XW'(q0));
  assign dist_raw = (rem >= XW'(125)) ? q0 + DW'(1) : q0;

  always_ff @(posedge clk) begin
    if (adv) begin
      dval[0] <= dist_raw;
      dmul[0] <= TW'(dist_raw) * TW'(RECIP10);
      dsat[0] <= (32'(dist_raw) > 32'(DIST_MAX)) ? DIST_MAX : 11'(dist_raw);
      digs[0] <= '0;
    end
  end

  // stages 4 to 7: one decimal digit each, ones digit first
  for (genvar k = 0; k < 4; k++) begin : g_digit
    logic [DW-1:0] q;
    logic [DW-1:0] r;
    logic [15:0]   digs_next;

    assign q = DW'(dmul[k][TW-1:RECIP10_SHIFT]);
    assign r = dval[k] - ((q << 3) + (q << 1));

    // digits so far with this stage's digit put in place
    always_comb begin
      digs_next = digs[k];
      digs_next[4*k +: 4] = r[3:0];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dval[k+1] <= q;
        dmul[k+1] <= TW'(q) * TW'(RECIP10);
        dsat[k+1] <= dsat[k];
        digs[k+1] <= digs_next;
      end
    end
  end

  // output register: pick characters by result kind
  always_ff @(posedge clk) begin
    if (adv) begin
      out_trigger <= fl[NST-2].trig;
      out_result  <= fl[NST-2].valid;
      out_timeout <= fl[NST-2].valid && fl[NST-2].timeout;
      if (!fl[NST-2].valid) begin
        out_distance  <= '0;
        out_thousands <= '0;
        out_hundreds  <= '0;
        out_tens      <= '0;
        out_ones      <= '0;
      end else if (fl[NST-2].timeout) begin
        out_distance  <= '0;
        out_thousands <= CHAR_DASH;
        out_hundreds  <= CHAR_DASH;
        out_tens      <= CHAR_DASH;
        out_ones      <= CHAR_DASH;
      end else begin
        out_distance  <= dsat[4];
        out_thousands <= CHAR_ZERO + 7'(digs[4][15:12]);
        out_hundreds  <= CHAR_ZERO + 7'(digs[4][11:8]);
        out_tens      <= CHAR_ZERO + 7'(digs[4][7:4]);
        out_ones      <= CHAR_ZERO + 7'(digs[4][3:0]);
      end
    end
  end

  // a timeout is always a completed measurement
  a_timeout_is_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_timeout |-> out_result)
    else $error("timeout flagged without a result");

  // ticks without a result carry no distance or characters
  a_idle_tick_blank: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_result |-> (out_distance == '0) && (out_ones == '0)
      && (out_tens == '0) && (out_hundreds == '0) && (out_thousands == '0))
    else $error("result fields set on a tick without a result");

  // a timeout shows dashes and zero distance
  a_timeout_dashes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_timeout |-> (out_distance == '0) && (out_ones == CHAR_DASH)
      && (out_thousands == CHAR_DASH))
    else $error("timeout result without dashes");

  // the queue is drained only when the pipe moves
  a_take_on_advance: assert property (@(posedge clk) disable iff (rst)
    job_take |-> adv && job_avail)
    else $error("job taken while pipe stalled");

endmodule

// ===== src/ultrasonic_echo_ranger.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger: time-of-flight ultrasonic ranging
// tick-driven trigger and echo timing with distance and ascii digit output
// ----------------------------------------------------------------------------
// Each slave transfer is one 1 us tick carrying the echo level in
// s_tdata[0]; every accepted tick yields exactly one master transfer, so the
// block takes one tick per clock cycle for as long as results are taken.
// For each accepted tick the sequencer pushes a job into a four-entry queue,
// and a nine-stage pipeline (count*17 by shift and add, one reciprocal
// multiply for /125 with a correction step, then one divide-by-ten multiply
// per digit stage) forms the distance and the four characters. When m_tready
// drops the queue fills up to its four entries before s_tready falls.
// period_ticks sits at byte address 0 and trigger_ticks at byte address 4
// of the register port.
module ultrasonic_echo_ranger #(
  parameter int ECHO_COUNTER_BITS = uer_pkg::ECHO_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // slave stream: tdata [0] echo_level, [7:1] zero
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  // master stream: tdata [0] trigger_out, [11:1] distance_cm,
  // [18:12] char_thousands, [25:19] char_hundreds, [32:26] char_tens,
  // [39:33] char_ones
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,
  // master tuser: [0] result_valid, [1] timed_out
  output logic [1:0]  m_tuser,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import uer_pkg::*;

  localparam int QW = JOB_BITS + ECHO_COUNTER_BITS;

  logic [19:0]                  period_ticks;
  logic [7:0]                   trigger_ticks;
  logic                         cfg_write;
  logic                         tick;
  job_t                         front_job, back_job;
  logic [ECHO_COUNTER_BITS-1:0] front_count, back_count;
  logic [QW-1:0]                q_head;
  logic                         q_full, q_avail, q_take;
  logic                         o_trig, o_result, o_timeout;
  logic [10:0]                  o_dist;
  logic [6:0]                   o_th, o_hu, o_te, o_on;

  // register port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_ticks  <= PERIOD_RESET;
      trigger_ticks <= TRIGGER_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_PERIOD:  period_ticks  <= pwdata[19:0];
        REG_TRIGGER: trigger_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PERIOD:  prdata = {12'd0, period_ticks};
      REG_TRIGGER: prdata = {24'd0, trigger_ticks};
      default:     prdata = '0;
    endcase
  end

  // tick transfer
  assign s_tready = !q_full;
  assign tick     = s_tvalid && s_tready;

  uer_front #(
    .ECHO_COUNTER_BITS(ECHO_COUNTER_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .tick         (tick),
    .echo_level   (s_tdata[0]),
    .period_ticks (period_ticks),
    .trigger_ticks(trigger_ticks),
    .job          (front_job),
    .job_count    (front_count)
  );

  uer_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (tick),
    .push_data({front_count, front_job}),
    .full     (q_full),
    .pop      (q_take),
    .not_empty(q_avail),
    .head     (q_head)
  );

  assign back_job   = job_t'(q_head[JOB_BITS-1:0]);
  assign back_count = q_head[QW-1:JOB_BITS];

  uer_back #(
    .ECHO_COUNTER_BITS(ECHO_COUNTER_BITS)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_avail    (q_avail),
    .job          (back_job),
    .job_count    (back_count),
    .job_take     (q_take),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_trigger  (o_trig),
    .out_result   (o_result),
    .out_timeout  (o_timeout),
    .out_distance (o_dist),
    .out_thousands(o_th),
    .out_hundreds (o_hu),
    .out_tens     (o_te),
    .out_ones     (o_on)
  );

  // result packing
  assign m_tdata = {o_on, o_te, o_hu, o_th, o_dist, o_trig};
  assign m_tuser = {o_timeout, o_result};

endmodule

// ===== dv/ultrasonic_echo_ranger_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger_tb: self-checking bench for the echo ranger
// drives echo ticks on the slave stream, predicts every master transfer
// in-bench and compares it field by field; registers are written and read
// back over the register port between phases while the stream is drained
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger_tb;
  import uer_pkg::*;

  localparam int ECHO_W = ECHO_BITS_DEF;
  localparam logic [ECHO_W-1:0] ECHO_MAX = {ECHO_W{1'b1}};
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int WATCHDOG_LIMIT = 2000;

  // one reading as it leaves the block
  typedef struct packed {
    logic        trig;
    logic        valid;
    logic        tmo;
    logic [10:0] dist_cm;
    logic [6:0]  c_th;
    logic [6:0]  c_hu;
    logic [6:0]  c_te;
    logic [6:0]  c_on;
  } range_res_t;

  typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;
  typedef enum int {ROW_TICK, ROW_PERIOD, ROW_TRIGGER} row_kind_t;

  // one line of the directed stimulus
  typedef struct {
    row_kind_t   kind;
    logic [31:0] val;
    int          reps;
    bit          typed;
    range_res_t  res;
  } stim_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  ultrasonic_echo_ranger dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // ranging state mirrored in the bench
  logic [19:0]       per_ticks = PERIOD_RESET;
  logic [7:0]        trig_ticks = TRIGGER_RESET;
  phase_t            ph = PH_IDLE;
  logic [19:0]       per_cnt = '0;
  logic [7:0]        pul_cnt = '0;
  logic [ECHO_W-1:0] echo_cnt = '0;
  logic              ovf = 1'b0;

  range_res_t pending_ranges[$];
  range_res_t pred_res;
  range_res_t want_res;
  range_res_t typed_res;
  bit         use_typed = 1'b0;
  int         readings_done = 0;
  int         errors = 0;
  int         stuck = 0;
  gap_mode_t  gap_mode = GAP_NONE;
  int         hold_reqs = 0;
  int         hold_taken = 0;
  int         hold_cnt = 0;
  int         len_plan[$];
  stim_row_t  stim_rows[$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // distance and display characters of a finished measurement
  function automatic range_res_t format_reading(input logic tmo,
                                                input logic [ECHO_W-1:0] cnt);
    range_res_t  r;
    int unsigned d;
    int unsigned v;
    r = '0;
    r.valid = 1'b1;
    if (tmo) begin
      r.tmo = 1'b1;
      r.c_th = CHAR_DASH;
      r.c_hu = CHAR_DASH;
      r.c_te = CHAR_DASH;
      r.c_on = CHAR_DASH;
      return r;
    end
    d = (cnt * 17) / 1000;
    r.dist_cm = (d > DIST_MAX) ? DIST_MAX : d[10:0];
    v = d;
    r.c_on = CHAR_ZERO + 7'(v % 10);
    v = v / 10;
    r.c_te = CHAR_ZERO + 7'(v % 10);
    v = v / 10;
    r.c_hu = CHAR_ZERO + 7'(v % 10);
    v = v / 10;
    r.c_th = CHAR_ZERO + 7'(v % 10);
    return r;
  endfunction

  // advance the ranging state by one tick and return its output
  function automatic range_res_t range_tick(input logic lvl);
    range_res_t r;
    r = '0;
    case (ph)
      PH_IDLE: begin
        per_cnt = per_cnt + 1'b1;
        if (per_cnt >= per_ticks) begin
          per_cnt = '0;
          pul_cnt = '0;
          echo_cnt = '0;
          ovf = 1'b0;
          ph = PH_TRIG;
        end
      end
      PH_TRIG: begin
        r.trig = 1'b1;
        pul_cnt = pul_cnt + 1'b1;
        if (pul_cnt >= trig_ticks) begin
          pul_cnt = '0;
          ph = PH_WAIT;
        end
      end
      PH_WAIT: begin
        if (lvl) begin
          echo_cnt = 1;
          ph = PH_COUNT;
        end
      end
      default: begin
        if (lvl && echo_cnt == ECHO_MAX) begin
          // counter overflow ends the measurement as a timeout
          echo_cnt = '0;
          ovf = 1'b1;
          r = format_reading(1'b1, '0);
          per_cnt = '0;
          ph = PH_IDLE;
        end else if (lvl) begin
          echo_cnt = echo_cnt + 1'b1;
        end else begin
          r = format_reading(ovf, echo_cnt);
          per_cnt = '0;
          ph = PH_IDLE;
        end
      end
    endcase
    if (r.valid) readings_done++;
    return r;
  endfunction

  function automatic range_res_t mk_res(input logic trig, input logic valid,
                                        input logic [10:0] dist_cm, input logic [6:0] th,
                                        input logic [6:0] hu, input logic [6:0] te,
                                        input logic [6:0] on);
    range_res_t r;
    r = '0;
    r.trig = trig;
    r.valid = valid;
    r.dist_cm = dist_cm;
    r.c_th = th;
    r.c_hu = hu;
    r.c_te = te;
    r.c_on = on;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // predict on every slave transfer, check every master transfer
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        pred_res = range_tick(s_tdata[0]);
        pending_ranges.push_back(use_typed ? typed_res : pred_res);
      end
      if (m_tvalid && m_tready) begin
        if (pending_ranges.size() == 0) begin
          $error("result transfer with no reading pending");
          errors++;
        end else begin
          want_res = pending_ranges.pop_front();
          check_field("trigger_out", want_res.trig, m_tdata[0]);
          check_field("result_valid", want_res.valid, m_tuser[0]);
          check_field("timed_out", want_res.tmo, m_tuser[1]);
          check_field("distance_cm", want_res.dist_cm, m_tdata[11:1]);
          check_field("char_thousands", want_res.c_th, m_tdata[18:12]);
          check_field("char_hundreds", want_res.c_hu, m_tdata[25:19]);
          check_field("char_tens", want_res.c_te, m_tdata[32:26]);
          check_field("char_ones", want_res.c_on, m_tdata[39:33]);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck <= 0;
    end else if (stuck >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // receiver: long hold-off on request, else random stalls per gap mode
  always @(negedge clk) begin
    if (hold_reqs != hold_taken) begin
      hold_taken = hold_reqs;
      hold_cnt = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      m_tready <= 1'b0;
    end else if (gap_mode == GAP_RECV) begin
      m_tready <= ($urandom_range(0, 99) >= 55);
    end else if (gap_mode == GAP_BOTH) begin
      m_tready <= ($urandom_range(0, 99) >= 19);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // one tick on the slave stream, with sender gaps; called at a falling edge
  task automatic send_tick(input logic lvl);
    int pct;
    pct = (gap_mode == GAP_SEND) ? 55 : (gap_mode == GAP_BOTH) ? 19 : 0;
    while ($urandom_range(0, 99) < pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, lvl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering ticks and let every pending reading come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_ranges.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_read_check(input logic idx, input logic [31:0] want);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field(idx == REG_PERIOD ? "prdata period_ticks" : "prdata trigger_ticks",
                want, prdata);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reg_write(input logic idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_PERIOD) per_ticks = val[19:0];
    else trig_ticks = val[7:0];
    @(negedge clk);
    reg_read_check(idx, idx == REG_PERIOD ? {12'd0, val[19:0]} : {24'd0, val[7:0]});
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(1, 25);
    if (r < 98) return $urandom_range(26, 150);
    return $urandom_range(151, 300);
  endfunction

  // measurements with random content: quiet wait, echo pulse, some glitchy echoes
  task automatic run_ticks(input int echo_goal, input int meas_goal);
    int   echo_n;
    int   meas0;
    int   wait_left;
    int   high_left;
    bit   planned;
    bit   glitchy;
    logic lvl;
    echo_n = 0;
    meas0 = readings_done;
    wait_left = 0;
    high_left = 0;
    planned = 1'b0;
    glitchy = 1'b0;
    while (echo_n < echo_goal || readings_done - meas0 < meas_goal) begin
      if (ph == PH_WAIT || ph == PH_COUNT) begin
        if (!planned) begin
          planned = 1'b1;
          wait_left = $urandom_range(0, 12);
          glitchy = (len_plan.size() == 0) && ($urandom_range(0, 7) == 0);
          high_left = (len_plan.size() != 0) ? len_plan.pop_front() : pick_len();
        end
        echo_n++;
        if (ph == PH_WAIT && wait_left > 0) begin
          wait_left--;
          lvl = 1'b0;
        end else if (glitchy) begin
          lvl = $urandom_range(0, 1);
        end else if (high_left > 0) begin
          high_left--;
          lvl = 1'b1;
        end else begin
          lvl = 1'b0;
        end
      end else begin
        // echo is ignored here, so it is just noise
        planned = 1'b0;
        lvl = ($urandom_range(0, 3) == 0);
      end
      send_tick(lvl);
    end
  endtask

  initial begin
    stim_row_t   row;
    logic [19:0] per;
    logic [7:0]  trg;

    // directed rows: reset values, register extremes, shortest and first-cm readings
    stim_rows.push_back('{ROW_TICK, 1, 2, 1'b1, '0});
    stim_rows.push_back('{ROW_PERIOD, 32'hFFFFF, 0, 1'b0, '0});
    stim_rows.push_back('{ROW_TICK, 0, 2, 1'b1, '0});
    stim_rows.push_back('{ROW_PERIOD, 0, 0, 1'b0, '0});
    stim_rows.push_back('{ROW_TRIGGER, 0, 0, 1'b0, '0});
    stim_rows.push_back('{ROW_TICK, 0, 1, 1'b1, '0});
    stim_rows.push_back('{ROW_TICK, 1, 1, 1'b1, mk_res(1, 0, 0, 0, 0, 0, 0)});
    stim_rows.push_back('{ROW_TICK, 0, 3, 1'b0, '0});
    stim_rows.push_back('{ROW_TICK, 1, 1, 1'b0, '0});
    stim_rows.push_back('{ROW_TICK, 0, 1, 1'b1,
                          mk_res(0, 1, 0, CHAR_ZERO, CHAR_ZERO, CHAR_ZERO, CHAR_ZERO)});
    stim_rows.push_back('{ROW_TRIGGER, 255, 0, 1'b0, '0});
    stim_rows.push_back('{ROW_PERIOD, 1, 0, 1'b0, '0});
    stim_rows.push_back('{ROW_TICK, 0, 1, 1'b0, '0});
    stim_rows.push_back('{ROW_TICK, 1, 255, 1'b0, '0});
    stim_rows.push_back('{ROW_TICK, 1, 59, 1'b0, '0});
    stim_rows.push_back('{ROW_TICK, 0, 1, 1'b1,
                          mk_res(0, 1, 1, CHAR_ZERO, CHAR_ZERO, CHAR_ZERO, CHAR_ZERO + 7'd1)});
    stim_rows.push_back('{ROW_TICK, 1, 3, 1'b0, '0});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // registers read back their reset values
    reg_read_check(REG_PERIOD, {12'd0, PERIOD_RESET});
    reg_read_check(REG_TRIGGER, {24'd0, TRIGGER_RESET});

    // directed part
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.kind == ROW_TICK) begin
        use_typed = row.typed;
        typed_res = row.res;
        repeat (row.reps) send_tick(row.val[0]);
        use_typed = 1'b0;
      end else begin
        wait_drained();
        reg_write(row.kind == ROW_PERIOD ? REG_PERIOD : REG_TRIGGER, row.val);
      end
    end

    // random part, one register setting and gap mode per phase
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin per = 20'd20; trg = 8'd10; end
        1: begin per = 20'd0; trg = 8'd1; end
        2: begin per = 20'd1; trg = 8'd0; end
        default: begin
          per = $urandom_range(0, 60);
          trg = $urandom_range(1, 20);
        end
      endcase
      wait_drained();
      reg_write(REG_PERIOD, {12'd0, per});
      reg_write(REG_TRIGGER, {24'd0, trg});
      gap_mode = gap_mode_t'(p);
      // long receiver hold-off so the block backs up into its input
      if (p == 0) hold_reqs++;
      run_ticks(24, 1);
    end

    // longest echo: a reading of ten centimetres
    wait_drained();
    reg_write(REG_PERIOD, 32'd5);
    reg_write(REG_TRIGGER, 32'd15);
    gap_mode = GAP_NONE;
    len_plan = '{589};
    run_ticks(0, 1);

    wait_drained();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/uer_pkg.sv
src/uer_front.sv
src/uer_queue.sv
src/uer_back.sv
src/ultrasonic_echo_ranger.sv
dv/ultrasonic_echo_ranger_tb.sv
